### rtl/efl_pkg.sv
// efl_pkg: shared types, constants and the emoji range check for utf8_emoji_filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package efl_pkg;

   localparam int BYTE_W       = 8;
   localparam int CP_W         = 21;
   localparam int LEN_W        = 3;
   localparam int GROUP_MAX    = 4;
   localparam int IDX_W        = 2;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [CP_W-1:0] EMOJI_A_LO = 21'h1F300;
   localparam logic [CP_W-1:0] EMOJI_A_HI = 21'h1FAFF;
   localparam logic [CP_W-1:0] EMOJI_B_LO = 21'h02600;
   localparam logic [CP_W-1:0] EMOJI_B_HI = 21'h027BF;
   localparam logic [CP_W-1:0] STAR_CP    = 21'h02B50;
   localparam logic [CP_W-1:0] HEART_CP   = 21'h02764;
   localparam logic [CP_W-1:0] VS16_CP    = 21'h0FE0F;
   localparam logic [CP_W-1:0] ZWJ_CP     = 21'h0200D;

   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;

   // one group of results caused by a single input transaction
   typedef struct packed {
      logic [GROUP_MAX-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W-1:0]                 last_idx;
      logic                             bare;
      logic                             eom;
   } entry_type;

   function automatic logic is_emoji(input logic [CP_W-1:0] cp);
      logic hit;
      hit = ((cp >= EMOJI_A_LO) && (cp <= EMOJI_A_HI)) ||
            ((cp >= EMOJI_B_LO) && (cp <= EMOJI_B_HI)) ||
            (cp == STAR_CP) || (cp == HEART_CP) ||
            (cp == VS16_CP) || (cp == ZWJ_CP);
      return hit;
   endfunction

endpackage

### rtl/efl_front.sv
// efl_front: utf8 sequence tracker; decodes each byte and builds at most one result group for it.
// Depends on efl_pkg.
`timescale 1ns / 1ps

module efl_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [efl_pkg::BYTE_W-1:0] in_byte,
   input  logic                      end_of_message,
   output logic                      push_valid,
   output efl_pkg::entry_type        push_entry
);

   logic [efl_pkg::GROUP_MAX-1:0][efl_pkg::BYTE_W-1:0] held_ff;
   logic [efl_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic [efl_pkg::LEN_W-1:0] exp_ff, exp_in;
   logic [efl_pkg::CP_W-1:0]  cp_ff, cp_in;

   logic                       cont;
   logic                       held_open;
   logic                       complete;
   logic                       fresh_emit;
   logic [efl_pkg::LEN_W-1:0]  lead_len;
   logic [efl_pkg::CP_W-1:0]   lead_cp;
   logic [efl_pkg::LEN_W-1:0]  cnt_inc;
   logic [efl_pkg::CP_W-1:0]   cp_next;
   logic [efl_pkg::LEN_W-1:0]  n_out;
   logic [efl_pkg::LEN_W-1:0]  n_minus;
   logic                       wr_en;
   logic [efl_pkg::IDX_W-1:0]  wr_idx;

   always_comb begin
      cont      = (in_byte[7:6] == efl_pkg::CONT_TAG);
      held_open = (cnt_ff != '0);
      cnt_inc   = cnt_ff + 3'd1;
      cp_next   = {cp_ff[efl_pkg::CP_W-7:0], in_byte[5:0]};
      complete  = (cnt_inc >= exp_ff);

      lead_len = efl_pkg::LEN_NONE;
      lead_cp  = '0;
      if (in_byte[7:5] == efl_pkg::LEAD2_TAG) begin
         lead_len = efl_pkg::LEN_TWO;
         lead_cp  = {16'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == efl_pkg::LEAD3_TAG) begin
         lead_len = efl_pkg::LEN_THREE;
         lead_cp  = {17'd0, in_byte[3:0]};
      end else if (in_byte[7:3] == efl_pkg::LEAD4_TAG) begin
         lead_len = efl_pkg::LEN_FOUR;
         lead_cp  = {18'd0, in_byte[2:0]};
      end
      fresh_emit = (lead_len == efl_pkg::LEN_NONE) || end_of_message;

      n_out  = '0;
      cnt_in = cnt_ff;
      exp_in = exp_ff;
      cp_in  = cp_ff;
      wr_en  = 1'b0;
      wr_idx = '0;

      if (held_open && cont) begin
         if (complete || end_of_message) begin
            cnt_in = '0;
            exp_in = '0;
            cp_in  = '0;
            n_out  = (complete && efl_pkg::is_emoji(cp_next)) ? 3'd0 : cnt_inc;
         end else begin
            cnt_in = cnt_inc;
            cp_in  = cp_next;
            wr_en  = 1'b1;
            wr_idx = cnt_ff[efl_pkg::IDX_W-1:0];
         end
      end else begin
         // flush whatever is held, then treat the byte as new
         n_out = cnt_ff + {2'd0, fresh_emit};
         if (fresh_emit) begin
            cnt_in = '0;
            exp_in = '0;
            cp_in  = '0;
         end else begin
            cnt_in = 3'd1;
            exp_in = lead_len;
            cp_in  = lead_cp;
            wr_en  = 1'b1;
            wr_idx = '0;
         end
      end

      // held bytes first, the new byte right after them
      for (int k = 0; k < efl_pkg::GROUP_MAX; k++) begin
         push_entry.bytes[k] = (3'(k) < cnt_ff) ? held_ff[k] : in_byte;
      end
      n_minus             = n_out - 3'd1;
      push_entry.last_idx = (n_out == '0) ? '0 : n_minus[efl_pkg::IDX_W-1:0];
      push_entry.bare     = (n_out == '0);
      push_entry.eom      = end_of_message;
      push_valid          = accept && ((n_out != '0) || end_of_message);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         exp_ff <= '0;
         cp_ff  <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         exp_ff <= exp_in;
         cp_ff  <= cp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         held_ff[wr_idx] <= in_byte;
      end
   end

   open_below_len: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (cnt_ff < exp_ff))
      else $error("open sequence holds as many bytes as its length");

   len_legal: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> ((exp_ff == efl_pkg::LEN_TWO) || (exp_ff == efl_pkg::LEN_THREE) ||
                          (exp_ff == efl_pkg::LEN_FOUR)))
      else $error("open sequence with bad expected length");

endmodule

### rtl/efl_fifo.sv
// efl_fifo: small register queue of result groups between front and back.
// Depends on efl_pkg.
`timescale 1ns / 1ps

module efl_fifo #(
   parameter int DEPTH = efl_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  efl_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               out_valid,
   output efl_pkg::entry_type out_entry,
   output logic               full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   efl_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   always_comb begin
      out_valid = (count_ff != '0);
      full      = (count_ff == CW'(DEPTH));
      out_entry = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && out_valid;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond depth");

   no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule

### rtl/efl_back.sv
// efl_back: takes result groups from the queue and emits them one result per cycle while rsp_ready is high.
// Depends on efl_pkg.
`timescale 1ns / 1ps

module efl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  efl_pkg::entry_type         q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [efl_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_message_end
);

   efl_pkg::entry_type        cur_ff;
   logic                      busy_ff, busy_in;
   logic [efl_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      last;
   logic                      take;

   always_comb begin
      last    = (idx_ff == cur_ff.last_idx);
      take    = !busy_ff || (rsp_ready && last);
      q_pop   = take && q_valid;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = q_valid;
         idx_in  = '0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 1'b1;
      end

      rsp_valid       = busy_ff;
      rsp_out_byte    = cur_ff.bare ? '0 : cur_ff.bytes[idx_ff];
      rsp_byte_valid  = !cur_ff.bare;
      rsp_message_end = cur_ff.eom && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
   end

   bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_message_end)
      else $error("bare result without end of message");

endmodule

### rtl/utf8_emoji_filter.sv
// utf8_emoji_filter: top level; front tracker, group queue and result sequencer.
// Depends on efl_pkg, efl_front, efl_fifo and efl_back.
`timescale 1ns / 1ps

// Takes one message byte per cycle while req_ready is high and returns the message
// with emoji sequences removed. Each accepted transaction yields zero to four results,
// which leave one per cycle while rsp_ready is high; bursts come from completed
// non-emoji multibyte sequences and from broken or cut-off ones. Results are
// registered in the group queue, then in the sequencer's current group. Result groups
// wait in a queue of QUEUE_DEPTH entries; req_ready drops only when that queue is
// full, so the rate is set by how fast rsp_ready drains the single output sequencer.
module utf8_emoji_filter #(
   parameter int QUEUE_DEPTH = efl_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [efl_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                       req_end_of_message,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [efl_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_message_end
);

   logic               accept;
   logic               push_valid;
   efl_pkg::entry_type push_entry;
   logic               q_valid;
   efl_pkg::entry_type q_entry;
   logic               q_pop;
   logic               q_full;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   efl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_in_byte),
      .end_of_message (req_end_of_message),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   efl_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_entry  (q_entry),
      .full       (q_full)
   );

   efl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end)
   );

endmodule
